[hdl/assert_macros.svh]
// Assertion macros shared by the RTL that carries inline checks.
// Needs nothing; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on rising edge, off during reset.
`define BMG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on rising edge, off during reset.
`define BMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bmg_pkg.sv]
// Shared types, constants and coefficient tables of the Gaussian pair generator.
// No dependencies.
package bmg_pkg;

	localparam int UNI_W        = 32;
	localparam int OUT_W        = 32;
	localparam int SIGMA_W      = 24;
	localparam int RAD_W        = 24;
	localparam int MAG_W        = 31;
	localparam int ANG_W        = 30;
	localparam int LOG_STEPS    = 32;
	localparam int LEN_W        = 38;
	localparam int SQRT_W       = 19;
	localparam int REM_W        = 20;
	localparam int HORNER_STEPS = 6;
	localparam int P2_FRAC      = 40;

	localparam int LAT_RAD     = 2 + LOG_STEPS + 3 + SQRT_W;
	localparam int LAT_ANG     = 3 + 3 * HORNER_STEPS + 1;
	localparam int LAT_OUT     = 4;
	localparam int ALIGN_DEPTH = LAT_RAD - LAT_ANG;

	localparam logic [RAD_W-1:0]   RADIUS_MAX  = 24'hFF_FFFF;
	localparam logic [24:0]        TWO_LN2_Q24 = 25'd23258160;
	localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;
	localparam logic [SIGMA_W-1:0] SIGMA_RESET = 24'd65536;

	localparam logic REG_SIGMA_SCALE = 1'b0;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	typedef struct packed {
		logic [ANG_W-1:0] th;
		logic [ANG_W-1:0] t2;
		logic [1:0]       quad;
		logic             swap;
	} ang_side_t;

	typedef struct packed {
		logic [MAG_W-1:0] cmag;
		logic             cneg;
		logic [MAG_W-1:0] smag;
		logic             sneg;
	} trig_t;

	// Taylor denominators, innermost term first.
	function automatic logic [7:0] horner_div(input logic sin_lane, input int unsigned step);
		logic [7:0] d;
		d = 8'd1;
		if (sin_lane) begin
			case (step)
				0: d = 8'd110;
				1: d = 8'd72;
				2: d = 8'd42;
				3: d = 8'd20;
				4: d = 8'd6;
				default: d = 8'd1;
			endcase
		end else begin
			case (step)
				0: d = 8'd132;
				1: d = 8'd90;
				2: d = 8'd56;
				3: d = 8'd30;
				4: d = 8'd12;
				5: d = 8'd2;
				default: d = 8'd1;
			endcase
		end
		return d;
	endfunction

	// floor(2^32 / d) for each denominator above.
	function automatic logic [31:0] horner_recip(input logic [7:0] d);
		logic [31:0] r;
		r = 32'd0;
		case (d)
			8'd110: r = 32'd39045157;
			8'd72:  r = 32'd59652323;
			8'd42:  r = 32'd102261126;
			8'd20:  r = 32'd214748364;
			8'd6:   r = 32'd715827882;
			8'd132: r = 32'd32537631;
			8'd90:  r = 32'd47721858;
			8'd56:  r = 32'd76695844;
			8'd30:  r = 32'd143165576;
			8'd12:  r = 32'd357913941;
			8'd2:   r = 32'h8000_0000;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/box_muller_gaussian_pair.sv]
// Top level of the Box-Muller Gaussian pair generator with its APB register.
// Depends on bmg_pkg, bmg_radius, bmg_angle, bmg_scale and assert_macros.svh.

// Turns each request of two uniform codes into a pair of Gaussian deviates
// dev_x = r*cos(a)*sigma and dev_y = r*sin(a)*sigma in signed Q15.16 (OUT_FRAC_BITS
// fraction bits), with r = sqrt(-2 ln u_radius) and a = 2*pi*u_angle; a radius code of
// zero gives the largest radius, and results past the 32-bit range saturate. The block
// is a fixed pipeline of 60 register stages: 56 in the radius path (normalize, 32
// squaring steps for log2, the 2 ln 2 multiply, 19 square-root steps), while the
// 22-stage sin/cos path runs alongside and waits in an alignment line, then 4 output
// stages for the products, rounding and saturation. Unless a stall holds the pipeline,
// a new request enters every clock and one deviate pair per cycle is sustained. When
// out_ready is low with a result waiting, the whole pipeline holds and in_ready drops
// in the same cycle; nothing is lost or repeated. sigma_scale (unsigned Q8.16, reset
// 1.0) sits at byte address 0 of the APB port and should be written only while no
// request is in flight.
module box_muller_gaussian_pair import bmg_pkg::*; #(
	parameter int UNIFORM_BITS  = 32,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [UNI_W-1:0]        u_angle,
	input  logic [UNI_W-1:0]        u_radius,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] dev_x,
	output logic signed [OUT_W-1:0] dev_y
);

	// configuration register
	logic               cfg_wr;
	logic [SIGMA_W-1:0] sigma_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_SIGMA_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
		end else if (cfg_wr) begin
			sigma_q <= pwdata[SIGMA_W-1:0];
		end
	end

	// reads outside the register map return zero
	assign prdata = (paddr[2] == REG_SIGMA_SCALE) ? {8'd0, sigma_q} : 32'd0;

	// advance every stage together unless a finished result is waiting
	logic adv;
	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv;

	logic             rad_vld;
	logic [RAD_W-1:0] rad_len;
	trig_t            ang_trig;

	bmg_radius #(
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_radius_path (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_in (in_valid),
		.code   (u_radius),
		.vld_out(rad_vld),
		.radius (rad_len)
	);

	bmg_angle #(
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_angle_path (
		.clk (clk),
		.en  (adv),
		.code(u_angle),
		.trig(ang_trig)
	);

	// delay the trig values until the matching radius comes out
	trig_t dly_q [ALIGN_DEPTH];

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_q[0] <= ang_trig;
			for (int i = 1; i < ALIGN_DEPTH; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	bmg_scale #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_in (rad_vld),
		.radius (rad_len),
		.trig   (dly_q[ALIGN_DEPTH-1]),
		.sigma  (sigma_q),
		.vld_out(out_valid),
		.dev_x  (dev_x),
		.dev_y  (dev_y)
	);

	`include "assert_macros.svh"

	`BMG_ASSERT_NEXT(a_sigma_write, clk, arst_n, cfg_wr, sigma_q == $past(pwdata[SIGMA_W-1:0]), "sigma_scale write not taken")
	`BMG_ASSERT_NEXT(a_sigma_hold, clk, arst_n, !cfg_wr, $stable(sigma_q), "sigma_scale changed without a write")
	`BMG_ASSERT_NEXT(a_stall_freeze, clk, arst_n, !adv, $stable(rad_vld) && $stable(rad_len), "radius path moved during a stall")
	`BMG_ASSERT_NOW(a_empty_accepts, clk, arst_n, !out_valid, in_ready, "request refused with an empty output register")

endmodule

[hdl/bmg_radius.sv]
// Radius pipeline: normalize, log2 by repeated squaring, scale by 2 ln 2, square root.
// Depends on bmg_pkg.
module bmg_radius import bmg_pkg::*; #(
	parameter int UNIFORM_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [UNI_W-1:0] code,
	output logic             vld_out,
	output logic [RAD_W-1:0] radius
);

	localparam logic [UNI_W-1:0] MASK = UNI_W'((64'd1 << UNIFORM_BITS) - 64'd1);

	logic [LAT_RAD-1:0] vld_sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr_q <= '0;
		end else if (en) begin
			vld_sr_q <= {vld_sr_q[LAT_RAD-2:0], vld_in};
		end
	end

	assign vld_out = vld_sr_q[LAT_RAD-1];

	// normalize, first half
	logic [UNI_W-1:0] c_in, x16, x8;
	logic             z16, z8;
	logic [UNI_W-1:0] nrm_x_s1;
	logic [1:0]       nrm_lz_s1;
	logic             nrm_zero_s1;

	assign c_in = code & MASK;
	assign z16  = (c_in[31:16] == 16'd0);
	assign x16  = z16 ? {c_in[15:0], 16'd0} : c_in;
	assign z8   = (x16[31:24] == 8'd0);
	assign x8   = z8 ? {x16[23:0], 8'd0} : x16;

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_x_s1    <= x8;
			nrm_lz_s1   <= {z16, z8};
			nrm_zero_s1 <= (c_in == '0);
		end
	end

	// normalize, second half; feeds the log chain
	logic [UNI_W-1:0]     log_x_s    [LOG_STEPS+1];
	logic [LOG_STEPS-1:0] log_f_s    [LOG_STEPS+1];
	logic [4:0]           log_lz_s   [LOG_STEPS+1];
	logic                 log_zero_s [LOG_STEPS+1];
	logic [UNI_W-1:0]     x4, x2, x1;
	logic                 z4, z2, z1;

	assign z4 = (nrm_x_s1[31:28] == 4'd0);
	assign x4 = z4 ? {nrm_x_s1[27:0], 4'd0} : nrm_x_s1;
	assign z2 = (x4[31:30] == 2'd0);
	assign x2 = z2 ? {x4[29:0], 2'd0} : x4;
	assign z1 = ~x2[31];
	assign x1 = z1 ? {x2[30:0], 1'b0} : x2;

	always_ff @(posedge clk) begin
		if (en) begin
			log_x_s[0]    <= x1;
			log_f_s[0]    <= '0;
			log_lz_s[0]   <= {nrm_lz_s1, z4, z2, z1};
			log_zero_s[0] <= nrm_zero_s1;
		end
	end

	// one log2 fraction bit per stage
	for (genvar gi = 0; gi < LOG_STEPS; gi++) begin : g_log
		logic [2*UNI_W-1:0] sq;
		logic [UNI_W:0]     sqh;

		assign sq  = log_x_s[gi] * log_x_s[gi];
		assign sqh = sq[2*UNI_W-1:UNI_W-1];

		always_ff @(posedge clk) begin
			if (en) begin
				log_x_s[gi+1]    <= sqh[UNI_W] ? sqh[UNI_W:1] : sqh[UNI_W-1:0];
				log_f_s[gi+1]    <= {log_f_s[gi][LOG_STEPS-2:0], sqh[UNI_W]};
				log_lz_s[gi+1]   <= log_lz_s[gi];
				log_zero_s[gi+1] <= log_zero_s[gi];
			end
		end
	end

	// -log2(u) in Q32
	logic [5:0]       up_w;
	logic [LEN_W-1:0] ln_s;
	logic             ln_zero_s;

	assign up_w = 6'(UNIFORM_BITS) - 6'd31 + {1'b0, log_lz_s[LOG_STEPS]};

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s      <= {up_w, 32'd0} - {6'd0, log_f_s[LOG_STEPS]};
			ln_zero_s <= log_zero_s[LOG_STEPS];
		end
	end

	// scale by 2 ln 2 in two partial products
	logic [56:0] pp_lo_s;
	logic [30:0] pp_hi_s;
	logic        pp_zero_s;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s   <= ln_s[31:0] * TWO_LN2_Q24;
			pp_hi_s   <= ln_s[LEN_W-1:32] * TWO_LN2_Q24;
			pp_zero_s <= ln_zero_s;
		end
	end

	logic [62:0] pp_sum;
	assign pp_sum = {pp_hi_s, 32'd0} + 63'(pp_lo_s);

	// restoring square root, one result bit per stage
	logic [LEN_W-1:0]  sq_n_s    [SQRT_W+1];
	logic [REM_W-1:0]  sq_rem_s  [SQRT_W+1];
	logic [SQRT_W-1:0] sq_root_s [SQRT_W+1];
	logic              sq_zero_s [SQRT_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_n_s[0]    <= pp_sum[61:24];
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_zero_s[0] <= pp_zero_s;
		end
	end

	for (genvar gi = 0; gi < SQRT_W; gi++) begin : g_sqrt
		logic [REM_W+1:0] cur, trial;
		logic             ge;

		assign cur   = {sq_rem_s[gi], sq_n_s[gi][LEN_W-1:LEN_W-2]};
		assign trial = {1'b0, sq_root_s[gi], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[gi+1]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
				sq_root_s[gi+1] <= {sq_root_s[gi][SQRT_W-2:0], ge};
				sq_n_s[gi+1]    <= {sq_n_s[gi][LEN_W-3:0], 2'b00};
				sq_zero_s[gi+1] <= sq_zero_s[gi];
			end
		end
	end

	assign radius = sq_zero_s[SQRT_W] ? RADIUS_MAX : RAD_W'(sq_root_s[SQRT_W]);

endmodule

[hdl/bmg_angle.sv]
// Angle pipeline: octant fold, phase to radians, Horner sin/cos, quadrant mapping.
// Depends on bmg_pkg.
module bmg_angle import bmg_pkg::*; #(
	parameter int UNIFORM_BITS
) (
	input  logic             clk,
	input  logic             en,
	input  logic [UNI_W-1:0] code,
	output trig_t            trig
);

	localparam logic [UNI_W-1:0] MASK = UNI_W'((64'd1 << UNIFORM_BITS) - 64'd1);

	logic [UNI_W-1:0] ph;
	logic [ANG_W-1:0] rem;
	logic [ANG_W-1:0] fold_rem_s1;
	logic [1:0]       fold_quad_s1;
	logic             fold_swap_s1;

	assign ph  = (code & MASK) << (UNI_W - UNIFORM_BITS);
	assign rem = ph[ANG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			fold_rem_s1  <= rem[ANG_W-1] ? ANG_W'(ONE_Q30 - {1'b0, rem}) : rem;
			fold_quad_s1 <= ph[UNI_W-1:ANG_W];
			fold_swap_s1 <= rem[ANG_W-1];
		end
	end

	logic [60:0]      thp;
	logic [ANG_W-1:0] th_s2;
	logic [1:0]       quad_s2;
	logic             swap_s2;

	assign thp = fold_rem_s1 * HALF_PI_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			th_s2   <= thp[59:30];
			quad_s2 <= fold_quad_s1;
			swap_s2 <= fold_swap_s1;
		end
	end

	logic [59:0] t2p;
	ang_side_t   grp_side_s [HORNER_STEPS+1];
	logic [30:0] grp_sacc_s [HORNER_STEPS+1];
	logic [30:0] grp_cacc_s [HORNER_STEPS+1];

	assign t2p = th_s2 * th_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			grp_side_s[0] <= '{th: th_s2, t2: t2p[59:30], quad: quad_s2, swap: swap_s2};
			grp_sacc_s[0] <= ONE_Q30;
			grp_cacc_s[0] <= ONE_Q30;
		end
	end

	// each term: multiply, reciprocal multiply, correct and subtract from one
	for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_hrn
		localparam logic [7:0]  CDIV = horner_div(1'b0, g);
		localparam logic [31:0] CREC = horner_recip(CDIV);

		ang_side_t   side_a_s, side_b_s;
		logic [60:0] cprod;
		logic [62:0] cqp;
		logic [30:0] cm_a_s, cm_b_s, cqe_b_s, cr, cq;

		assign cprod = grp_side_s[g].t2 * grp_cacc_s[g];
		assign cqp   = cm_a_s * CREC;
		assign cr    = cm_b_s - 31'(cqe_b_s * CDIV);
		assign cq    = (cr >= 31'(CDIV)) ? cqe_b_s + 31'd1 : cqe_b_s;

		always_ff @(posedge clk) begin
			if (en) begin
				side_a_s          <= grp_side_s[g];
				cm_a_s            <= cprod[60:30];
				side_b_s          <= side_a_s;
				cm_b_s            <= cm_a_s;
				cqe_b_s           <= cqp[62:32];
				grp_side_s[g+1]   <= side_b_s;
				grp_cacc_s[g+1]   <= ONE_Q30 - cq;
			end
		end

		if (g < HORNER_STEPS - 1) begin : g_sin_term
			localparam logic [7:0]  SDIV = horner_div(1'b1, g);
			localparam logic [31:0] SREC = horner_recip(SDIV);

			logic [60:0] sprod;
			logic [62:0] sqp;
			logic [30:0] sm_a_s, sm_b_s, sqe_b_s, sr, sq;

			assign sprod = grp_side_s[g].t2 * grp_sacc_s[g];
			assign sqp   = sm_a_s * SREC;
			assign sr    = sm_b_s - 31'(sqe_b_s * SDIV);
			assign sq    = (sr >= 31'(SDIV)) ? sqe_b_s + 31'd1 : sqe_b_s;

			always_ff @(posedge clk) begin
				if (en) begin
					sm_a_s          <= sprod[60:30];
					sm_b_s          <= sm_a_s;
					sqe_b_s         <= sqp[62:32];
					grp_sacc_s[g+1] <= ONE_Q30 - sq;
				end
			end
		end else begin : g_sin_tail
			// sine series ends with a multiply by theta; hold it through the term slots
			logic [60:0] sprod;
			logic [30:0] sm_a_s, sm_b_s;

			assign sprod = grp_side_s[g].th * grp_sacc_s[g];

			always_ff @(posedge clk) begin
				if (en) begin
					sm_a_s          <= sprod[60:30];
					sm_b_s          <= sm_a_s;
					grp_sacc_s[g+1] <= sm_b_s;
				end
			end
		end
	end

	// undo the octant fold, then place by quadrant
	ang_side_t        fin;
	logic [MAG_W-1:0] sv, cv;
	trig_t            trig_nxt;
	trig_t            trig_s;

	assign fin = grp_side_s[HORNER_STEPS];
	assign sv  = fin.swap ? grp_cacc_s[HORNER_STEPS] : grp_sacc_s[HORNER_STEPS];
	assign cv  = fin.swap ? grp_sacc_s[HORNER_STEPS] : grp_cacc_s[HORNER_STEPS];

	always_comb begin
		case (fin.quad)
			QUAD_0:  trig_nxt = '{cmag: cv, cneg: 1'b0, smag: sv, sneg: 1'b0};
			QUAD_1:  trig_nxt = '{cmag: sv, cneg: 1'b1, smag: cv, sneg: 1'b0};
			QUAD_2:  trig_nxt = '{cmag: cv, cneg: 1'b1, smag: sv, sneg: 1'b1};
			default: trig_nxt = '{cmag: sv, cneg: 1'b0, smag: cv, sneg: 1'b1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s <= trig_nxt;
		end
	end

	assign trig = trig_s;

endmodule

[hdl/bmg_scale.sv]
// Output stage: radius times trig, times sigma, round, saturate, sign; holds the result.
// Depends on bmg_pkg.
module bmg_scale import bmg_pkg::*; #(
	parameter int OUT_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [RAD_W-1:0]        radius,
	input  trig_t                   trig,
	input  logic [SIGMA_W-1:0]      sigma,
	output logic                    vld_out,
	output logic signed [OUT_W-1:0] dev_x,
	output logic signed [OUT_W-1:0] dev_y
);

	localparam int          SH      = P2_FRAC - OUT_FRAC_BITS;
	localparam logic [57:0] RND     = 58'd1 << (SH - 1);
	localparam logic [57:0] LIM_POS = 58'h7FFF_FFFF;
	localparam logic [57:0] LIM_NEG = 58'h8000_0000;

	logic [LAT_OUT-1:0] vld_sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr_q <= '0;
		end else if (en) begin
			vld_sr_q <= {vld_sr_q[LAT_OUT-2:0], vld_in};
		end
	end

	assign vld_out = vld_sr_q[LAT_OUT-1];

	logic [MAG_W-1:0] mag_in [2];
	logic             neg_in [2];
	logic [OUT_W-1:0] dev_s4 [2];

	assign mag_in[0] = trig.cmag;
	assign neg_in[0] = trig.cneg;
	assign mag_in[1] = trig.smag;
	assign neg_in[1] = trig.sneg;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [54:0] p1p;
		logic [32:0] p1_s1;
		logic        neg_s1, neg_s2, neg_s3;
		logic [40:0] hi_s2;
		logic [39:0] lo_s2;
		logic [56:0] p2_s3;
		logic [57:0] rnd, v, lim, vc;

		assign p1p = mag_in[l] * radius;
		assign rnd = {1'b0, p2_s3} + RND;
		assign v   = rnd >> SH;
		assign lim = neg_s3 ? LIM_NEG : LIM_POS;
		assign vc  = (v > lim) ? lim : v;

		always_ff @(posedge clk) begin
			if (en) begin
				p1_s1     <= p1p[54:22];
				neg_s1    <= neg_in[l];
				hi_s2     <= p1_s1[32:16] * sigma;
				lo_s2     <= p1_s1[15:0] * sigma;
				neg_s2    <= neg_s1;
				p2_s3     <= {hi_s2, 16'd0} + 57'(lo_s2);
				neg_s3    <= neg_s2;
				dev_s4[l] <= neg_s3 ? (32'd0 - vc[OUT_W-1:0]) : vc[OUT_W-1:0];
			end
		end
	end

	assign dev_x = dev_s4[0];
	assign dev_y = dev_s4[1];

endmodule

[dv/box_muller_gaussian_pair_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for box_muller_gaussian_pair: random and corner requests,
// an exact integer model of the deviate pair, APB writes of sigma_scale. Needs bmg_pkg.
module box_muller_gaussian_pair_tb;
	import bmg_pkg::*;

	localparam int IDLE_MAX      = 18;
	localparam int DRAIN_CYCLES  = 200;
	localparam int WATCHDOG_LIM  = 5000;
	localparam logic [2:0] ADDR_SIGMA = 3'd0;

	typedef struct {
		logic [31:0] ang;
		logic [31:0] rad;
	} uniform_pair_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
	} deviate_pair_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [31:0] u_angle, u_radius;
	logic signed [31:0] dev_x, dev_y;

	box_muller_gaussian_pair DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .u_angle(u_angle), .u_radius(u_radius),
		.out_valid(out_valid), .out_ready(out_ready), .dev_x(dev_x), .dev_y(dev_y)
	);

	uniform_pair_t pending_reqs[$];
	deviate_pair_t expected_devs[$];
	logic [23:0] sigma_model;
	int mismatches, results_seen, reqs_sent, cfg_writes, idle_cycles;
	bit stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Radius in Q8.16: sqrt(-2 ln u) via log2 by repeated squaring.
	function automatic logic [23:0] radius_q16(input logic [31:0] c);
		int p;
		logic [63:0] x, f, len, r2, n, res, bitv;
		if (c == 0)
			return RADIUS_MAX;
		p = 31;
		while (p > 0 && c[p] == 1'b0)
			p--;
		x = 64'(c) << (31 - p);
		f = 0;
		for (int i = 0; i < 32; i++) begin
			x = (x * x) >> 31;
			f = f << 1;
			if (x >= 64'h1_0000_0000) begin
				f = f | 64'd1;
				x = x >> 1;
			end
		end
		len = (64'(32 - p) << 32) - f;
		r2 = (len * 64'(TWO_LN2_Q24)) >> 24;
		n = r2;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[23:0];
	endfunction

	function automatic logic [63:0] taylor_poly(input logic [63:0] t2, input bit sin_lane);
		logic [63:0] acc;
		int n;
		acc = 64'(ONE_Q30);
		n = sin_lane ? 5 : 6;
		for (int i = 0; i < n; i++)
			acc = 64'(ONE_Q30) - ((t2 * acc) >> 30) / 64'(horner_div(sin_lane, i));
		return acc;
	endfunction

	function automatic logic [31:0] scaled_deviate(input logic [63:0] mag, input bit neg,
			input logic [23:0] r);
		logic [63:0] p1, p2, v, lim;
		p1 = (mag * 64'(r)) >> 22;
		p2 = p1 * 64'(sigma_model);
		v = (p2 + (64'd1 << 23)) >> 24;
		lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
		if (v > lim)
			v = lim;
		if (neg)
			v = 64'd0 - v;
		return v[31:0];
	endfunction

	function automatic deviate_pair_t gaussian_pair(input uniform_pair_t u);
		deviate_pair_t d;
		logic [23:0] r;
		logic [1:0] q;
		logic [63:0] rem, th, t2, s, c, tmp, cm, sm;
		bit cn, sn;
		r = radius_q16(u.rad);
		q = u.ang[31:30];
		rem = 64'(u.ang[29:0]);
		tmp = 0;
		if (rem >= (64'd1 << 29)) begin
			rem = (64'd1 << 30) - rem;
			tmp = 1;
		end
		th = (rem * 64'(HALF_PI_Q30)) >> 30;
		t2 = (th * th) >> 30;
		s = (th * taylor_poly(t2, 1'b1)) >> 30;
		c = taylor_poly(t2, 1'b0);
		if (tmp == 1) begin
			tmp = s;
			s = c;
			c = tmp;
		end
		case (q)
			2'd0: begin cm = c; cn = 0; sm = s; sn = 0; end
			2'd1: begin cm = s; cn = 1; sm = c; sn = 0; end
			2'd2: begin cm = c; cn = 1; sm = s; sn = 1; end
			default: begin cm = s; cn = 0; sm = c; sn = 1; end
		endcase
		d.x = scaled_deviate(cm, cn, r);
		d.y = scaled_deviate(sm, sn, r);
		return d;
	endfunction

	// Driver: pop one request, hold valid until accepted, then a random gap.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			u_angle  <= '0;
			u_radius <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_devs.push_back(gaussian_pair('{ang: u_angle, rad: u_radius}));
				reqs_sent++;
			end
			if (in_valid && !in_ready) begin
				// hold the current request
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				uniform_pair_t u;
				u = pending_reqs.pop_front();
				in_valid <= 1'b1;
				u_angle  <= u.ang;
				u_radius <= u.rad;
				send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expectation; stall at random.
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				deviate_pair_t e;
				int g;
				results_seen++;
				if (expected_devs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%h y=%h", dev_x, dev_y);
				end else begin
					e = expected_devs.pop_front();
					if (e.x !== dev_x || e.y !== dev_y) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: exp x=%h y=%h got x=%h y=%h",
								results_seen, e.x, e.y, dev_x, dev_y);
					end
				end
				g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
				recv_gap  <= g;
				out_ready <= (g == 0);
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles with no accepted request or result and no APB access.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIM) begin
			$display("watchdog: no progress, %0d results pending", expected_devs.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_SIGMA)
			sigma_model = data[23:0];
		cfg_writes++;
	endtask

	// Wait until the pipeline has emptied before touching the register.
	task automatic drain_pipeline();
		while (pending_reqs.size() > 0 || in_valid || expected_devs.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic queue_req(input logic [31:0] a, input logic [31:0] r);
		pending_reqs.push_back('{ang: a, rad: r});
	endtask

	// Uniform codes with a corner bias: zero, all ones, tiny, near octant folds and quadrant edges, powers of two.
	function automatic logic [31:0] corner_code();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 255);
			3: return {2'($urandom_range(0, 3)), 30'h2000_0000} + $urandom_range(0, 7) - 4;
			4: return {2'($urandom_range(0, 3)), 30'd0} + $urandom_range(0, 3);
			5: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				queue_req(corner_code(), corner_code());
			else
				queue_req($urandom, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		sigma_model = SIGMA_RESET;
		mismatches = 0; results_seen = 0; reqs_sent = 0; cfg_writes = 0; idle_cycles = 0;
		stim_done = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each quadrant and octant fold, zero and full-scale codes, sigma 1.0.
		queue_req(32'd0, 32'd0);
		queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(32'h4000_0000, 32'h8000_0000);
		queue_req(32'h8000_0000, 32'd1);
		queue_req(32'hC000_0000, 32'h0000_FFFF);
		queue_req(32'h2000_0000, 32'h1234_5678);
		queue_req(32'h1FFF_FFFF, 32'hAAAA_AAAA);
		queue_req(32'h6000_0001, 32'h5555_5555);
		queue_req(32'hA000_0000, 32'd2);
		queue_req(32'hE000_0000, 32'hFFFF_FFFE);
		queue_req(32'h3FFF_FFFF, 32'd0);
		queue_req(32'h7FFF_FFFF, 32'h0000_0100);
		drain_pipeline();

		// Largest sigma drives saturation in both directions.
		apb_write(ADDR_SIGMA, 32'hFFFF_FFFF);
		queue_req(32'd0, 32'd0);
		queue_req(32'h8000_0000, 32'd0);
		queue_req(32'h4000_0000, 32'd1);
		queue_req(32'hC000_0000, 32'd1);
		queue_req(32'h2000_0000, 32'h8000_0000);
		random_phase(150);
		drain_pipeline();

		apb_write(ADDR_SIGMA, 32'd0);
		queue_req(32'd0, 32'd0);
		random_phase(100);
		drain_pipeline();

		apb_write(ADDR_SIGMA, 32'd1);
		random_phase(100);
		drain_pipeline();

		apb_write(ADDR_SIGMA, {8'hA5, 24'($urandom_range(1, 24'hFF_FFFF))});
		random_phase(200);
		drain_pipeline();

		apb_write(ADDR_SIGMA, 32'(SIGMA_RESET));
		random_phase(230);
		drain_pipeline();

		stim_done = 1;
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d sigma writes incl. 0 and max",
			reqs_sent, results_seen, cfg_writes);
		if (mismatches == 0 && expected_devs.size() == 0)
			$display("[ OK ] regression clean");
		else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_devs.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[box_muller_gaussian_pair.f]
+incdir+hdl
hdl/bmg_pkg.sv
hdl/bmg_radius.sv
hdl/bmg_angle.sv
hdl/bmg_scale.sv
hdl/box_muller_gaussian_pair.sv
dv/box_muller_gaussian_pair_tb.sv
